/* sv/rqsk_pkg.sv */
// Package for record_quicksort_by_key: shared constants.
// No dependencies.
package rqsk_pkg;
   localparam int unsigned TAG_BITS = 6;
   localparam int unsigned IO_KEY_BITS = 8;
   localparam logic [0:0] REG_DESCENDING = 1'b0;
endpackage

/* sv/record_quicksort_by_key_top.sv */
// Top level of record_quicksort_by_key: record store, range stack and sort sequencer.
// Depends on rqsk_pkg.
//
// Records arrive one per cycle on req_ (tdata: key_age[7:0], record_tag[13:8]; tlast: last_in)
// and are written into a record memory with one write and one read port. The transaction with
// tlast closes the set: the block stops taking input and runs Hoare quicksort with the middle
// pivot, keeping pending ranges on an explicit stack. One shared key compare unit and one record
// memory do all the work. Each compare step reads a record and then compares it, each swap
// writes the two records back, and every popped range adds a stack read, a pivot fetch and the
// pushes. Output then reads each record and presents it, holding on any rsp_tready stall. The
// results leave in order on rsp_, with tlast on the final one. Records beyond MAX_RECORDS are
// dropped. No clearing pass is needed.
module record_quicksort_by_key_top #(
   parameter int MAX_RECORDS = 64,
   parameter int KEY_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_age[7:0], record_tag[13:8], zeros
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // sorted_key[7:0], sorted_tag[13:8], zeros
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW = AW + 1;
   localparam int TB = rqsk_pkg::TAG_BITS;
   localparam int RW = KEY_BITS + TB;
   localparam logic signed [CW+1:0] ONE_S = 1;

   typedef enum logic [3:0] {
      S_LOAD, S_POPW, S_POP, S_PIV, S_PIVW, S_LRD, S_LCMP, S_RRD, S_RCMP,
      S_SWP1, S_SWP2, S_PUSH1, S_PUSH2, S_OUTRD, S_OUT
   } state_type;

   state_type state_ff;
   logic desc_ff;
   logic [CW-1:0] count_ff, sp_ff, base_ff, len_ff, out_ff;
   logic signed [CW+1:0] li_ff, ri_ff;
   logic [KEY_BITS-1:0] piv_ff;
   logic [RW-1:0] lrec_ff;

   logic [RW-1:0] mem [MAX_RECORDS];
   logic [2*CW-1:0] stk [MAX_RECORDS];
   logic [RW-1:0] rd_ff;
   logic [2*CW-1:0] srd_ff;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [RW-1:0] wdata;

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, desc_ff};
   always_ff @(posedge clock) begin
      if (reset) desc_ff <= 1'b0;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr == {rqsk_pkg::REG_DESCENDING, 1'b0} && csr_pready)
         desc_ff <= csr_pwdata[0];
   end

   // shared compare unit: a strictly ahead of b
   function automatic logic goes_first(input logic d, input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b);
      goes_first = d ? (a > b) : (a < b);
   endfunction

   logic [KEY_BITS-1:0] cmp_a, cmp_b;
   logic cmp_q;
   assign cmp_q = goes_first(desc_ff, cmp_a, cmp_b);
   logic [KEY_BITS-1:0] rd_key;
   assign rd_key = rd_ff[KEY_BITS-1:0];
   always_comb begin
      if (state_ff == S_LCMP) begin cmp_a = rd_key; cmp_b = piv_ff; end
      else begin cmp_a = piv_ff; cmp_b = rd_key; end
   end

   logic acc;
   assign req_tready = (state_ff == S_LOAD);
   assign acc = req_tvalid && req_tready;

   logic [CW+1:0] li_abs, ri_abs;
   assign li_abs = CW'(base_ff) + li_ff;
   assign ri_abs = CW'(base_ff) + ri_ff;
   logic signed [CW+1:0] lenm1;
   assign lenm1 = $signed({2'b0, len_ff}) - ONE_S;

   always_comb begin
      raddr = AW'(out_ff);
      we = 1'b0; waddr = AW'(count_ff); wdata = lrec_ff;
      case (state_ff)
         S_LOAD: begin
            we = acc && (count_ff < CW'(MAX_RECORDS));
            wdata = {req_tdata[13:8], KEY_BITS'(req_tdata[7:0])};
         end
         S_PIV: raddr = AW'(base_ff + (len_ff >> 1));
         S_LRD, S_LCMP: raddr = AW'(li_abs);
         S_RRD, S_RCMP: raddr = AW'(ri_abs);
         S_SWP1: begin we = 1'b1; waddr = AW'(li_abs); wdata = rd_ff; end
         S_SWP2: begin we = 1'b1; waddr = AW'(ri_abs); wdata = lrec_ff; end
         S_OUT: raddr = AW'(out_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // stack memory: write on push, registered read of top
   logic spush;
   logic [2*CW-1:0] sdata;
   logic [CW-1:0] pb, pl;
   always_comb begin
      spush = 1'b0; pb = base_ff; pl = CW'(ri_ff + 1);
      if (state_ff == S_PUSH1) begin
         spush = (ri_ff + 1 < $signed({2'b0, len_ff})) && (ri_ff + 1 >= 2);
      end else if (state_ff == S_PUSH2) begin
         pb = CW'(li_abs); pl = CW'($signed({2'b0, len_ff}) - li_ff);
         spush = (li_ff > 0) && (pl >= 2);
      end else if (state_ff == S_LOAD) begin
         pb = '0; pl = count_ff + CW'(we);
         spush = acc && req_tlast && (pl >= 2);
      end
      sdata = {pb, pl};
   end
   always_ff @(posedge clock) begin
      if (spush && sp_ff < CW'(MAX_RECORDS)) stk[AW'(sp_ff)] <= sdata;
      srd_ff <= stk[AW'(sp_ff - 1'b1)];
   end
   logic do_push;
   assign do_push = spush && sp_ff < CW'(MAX_RECORDS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; count_ff <= '0; sp_ff <= '0; out_ff <= '0;
         li_ff <= '0; ri_ff <= '0; piv_ff <= '0; base_ff <= '0; len_ff <= '0;
      end else begin
         if (do_push) sp_ff <= sp_ff + 1'b1;
         case (state_ff)
            S_LOAD: if (acc) begin
               count_ff <= count_ff + CW'(we);
               if (req_tlast) begin
                  out_ff <= '0;
                  state_ff <= S_POPW;
               end
            end
            // stack pointer is stable here, so srd_ff picks up the current top
            S_POPW: state_ff <= S_POP;
            S_POP: begin
               if (sp_ff == '0) state_ff <= S_OUTRD;
               else begin
                  base_ff <= srd_ff[2*CW-1:CW]; len_ff <= srd_ff[CW-1:0];
                  sp_ff <= sp_ff - 1'b1;
                  if (srd_ff[2*CW-1:CW] + srd_ff[CW-1:0] > count_ff || srd_ff[CW-1:0] < 2)
                     state_ff <= S_POPW;
                  else state_ff <= S_PIV;
               end
            end
            S_PIV: state_ff <= S_PIVW; // memory reads middle element
            S_PIVW: begin
               piv_ff <= rd_key; li_ff <= '0; ri_ff <= lenm1; state_ff <= S_LRD;
            end
            S_LRD: state_ff <= S_LCMP;
            S_LCMP: begin
               if (li_ff < lenm1 && cmp_q) begin
                  li_ff <= li_ff + ONE_S; state_ff <= S_LRD;
               end else begin
                  lrec_ff <= rd_ff; state_ff <= S_RRD;
               end
            end
            S_RRD: state_ff <= S_RCMP;
            S_RCMP: begin
               if (ri_ff > 0 && cmp_q) begin
                  ri_ff <= ri_ff - ONE_S; state_ff <= S_RRD;
               end else if (li_ff <= ri_ff) state_ff <= S_SWP1;
               else state_ff <= S_PUSH1;
            end
            S_SWP1: state_ff <= S_SWP2;
            S_SWP2: begin
               li_ff <= li_ff + ONE_S; ri_ff <= ri_ff - ONE_S;
               state_ff <= (li_ff + 1 <= ri_ff - 1) ? S_LRD : S_PUSH1;
            end
            S_PUSH1: state_ff <= S_PUSH2;
            S_PUSH2: state_ff <= S_POPW;
            S_OUTRD: state_ff <= (count_ff == '0) ? S_LOAD : S_OUT;
            S_OUT: if (rsp_tready) begin
               if (out_ff + 1'b1 == count_ff) begin
                  count_ff <= '0; state_ff <= S_LOAD;
               end else begin
                  out_ff <= out_ff + 1'b1; state_ff <= S_OUTRD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {2'b00, rd_ff[RW-1:KEY_BITS], 8'(rd_ff[KEY_BITS-1:0])};
   assign rsp_tlast = (out_ff + 1'b1 == count_ff);

   a_no_input_while_sorting: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_LOAD |-> !req_tready) else $error("ready while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS)) else $error("count overflow");
   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_ff < count_ff) else $error("output index past set");
endmodule
